// ----- sv/dww_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dww_pkg
// Shared types and constants of the delayed writeback wheel.
// ----------------------------------------------------------------------------
package dww_pkg;

  localparam int unsigned WheelSlotsDef   = 64;
  localparam int unsigned MovesPerSlotDef = 8;
  localparam int unsigned RegCountDef     = 256;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_BRANCH = 2'd1,
    OP_TICK   = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_STATUS = 3'd0,
    KIND_WRITE  = 3'd1,
    KIND_BRANCH = 3'd2,
    KIND_BUSY   = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_CONFLICT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_PUSH_HI,
    S_PUSH_REL,
    S_REPLY,
    S_WALK_RD,
    S_WALK_EX,
    S_FLUSH,
    S_BRANCH
  } state_e;

endpackage
`default_nettype wire

// ----- sv/dww_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dww_in_if / dww_out_if
// Request and result channels of the delayed writeback wheel.
// ----------------------------------------------------------------------------
interface dww_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  dest;
  logic [63:0] value;
  logic [63:0] value_hi;
  logic        wide;
  logic        mark_busy;
  logic [6:0]  latency;
  logic [31:0] target;
  logic [31:0] handler;

  modport source (output valid, op, dest, value, value_hi, wide, mark_busy, latency,
                  target, handler, input ready);
  modport sink (input valid, op, dest, value, value_hi, wide, mark_busy, latency,
                target, handler, output ready);
endinterface

interface dww_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  status;
  logic [7:0]  reg_index;
  logic [63:0] write_value;
  logic        busy_res;
  logic [31:0] branch_target;
  logic [31:0] branch_handler;
  logic        last;

  modport source (output valid, kind, status, reg_index, write_value, busy_res,
                  branch_target, branch_handler, last, input ready);
  modport sink (input valid, kind, status, reg_index, write_value, busy_res,
                branch_target, branch_handler, last, output ready);
endinterface
`default_nettype wire

// ----- sv/delayed_writeback_wheel.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delayed_writeback_wheel
// Timing wheel of delayed register writes and branches with a busy scoreboard.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  in_i    | in  | op, dest, value, value_hi, wide, mark_busy, latency, target, handler
//  out_o   | out | kind, status, reg_index, write_value, busy_res, branch_target,
//          |     | branch_handler, last
//
// Write: execute, then one push per extra entry (wide half, busy release), then reply;
// branch and query: execute, then reply. Tick: walk each queued entry, then a branch.
// After reset a clearing pass over the busy RAM runs, and no requests are taken.
// Results sit in an output register; a stalled sink holds the sequencer.
module delayed_writeback_wheel #(
  parameter int unsigned WHEEL_SLOTS    = dww_pkg::WheelSlotsDef,
  parameter int unsigned MOVES_PER_SLOT = dww_pkg::MovesPerSlotDef,
  parameter int unsigned REG_COUNT      = dww_pkg::RegCountDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dww_in_if.sink    in_i,
  dww_out_if.source out_o
);
  import dww_pkg::*;

  localparam int unsigned SW  = $clog2(WHEEL_SLOTS);
  localparam int unsigned RW  = $clog2(REG_COUNT);
  localparam int unsigned CW  = $clog2(MOVES_PER_SLOT + 1);
  localparam int unsigned MD  = WHEEL_SLOTS * MOVES_PER_SLOT;
  localparam int unsigned AW  = $clog2(MD);
  localparam int unsigned MTW = CW + 1 + 64;
  localparam int unsigned MVW = RW + 1 + 64;

  // constant reduction tables
  logic [SW-1:0] lat_tbl [128];
  logic [RW-1:0] dm_tbl  [256];

  for (genvar g = 0; g < 128; g++) begin : g_lat
    localparam int unsigned LM = g % WHEEL_SLOTS;
    assign lat_tbl[g] = SW'(LM);
  end
  for (genvar g = 0; g < 256; g++) begin : g_dm
    localparam int unsigned DM = g % REG_COUNT;
    assign dm_tbl[g] = RW'(DM);
  end

  state_e state_q, state_d;

  logic [SW-1:0]          head_q;
  logic [WHEEL_SLOTS-1:0] slot_vld_q;
  logic [RW-1:0]          clr_q;
  op_e                    op_q;
  logic [RW-1:0]          dest_q, dp1_q;
  logic [63:0]            value_q, value_hi_q;
  logic                   wide_q, mark_q, rel_q;
  logic [SW-1:0]          slot_q;
  logic [31:0]            target_q, handler_q;
  logic [CW-1:0]          idx_q, cnt_q, p_q;
  logic                   br_vld_q;
  logic [31:0]            br_t_q, br_h_q;
  logic                   pend_q;
  logic [RW-1:0]          pend_reg_q;
  logic [63:0]            pend_val_q;
  kind_e                  rkind_q;
  status_e                rstatus_q;
  logic                   rbusy_q;

  logic                   out_valid_q;
  kind_e                  o_kind_q;
  status_e                o_status_q;
  logic [7:0]             o_reg_q;
  logic [63:0]            o_val_q;
  logic                   o_busy_q;
  logic [31:0]            o_t_q, o_h_q;
  logic                   o_last_q;

  // slot selection
  logic [RW-1:0] dm_in;
  logic [SW-1:0] lm_in, slot_in, slot_sel;
  logic [SW+1:0] sum;

  assign dm_in = dm_tbl[in_i.dest];
  assign lm_in = lat_tbl[in_i.latency];
  assign sum   = {2'b00, head_q} + {2'b00, lm_in} + (SW+2)'(WHEEL_SLOTS - 1);

  always_comb begin
    if (sum >= (SW+2)'(2 * WHEEL_SLOTS)) begin
      slot_in = SW'(sum - (SW+2)'(2 * WHEEL_SLOTS));
    end else if (sum >= (SW+2)'(WHEEL_SLOTS)) begin
      slot_in = SW'(sum - (SW+2)'(WHEEL_SLOTS));
    end else begin
      slot_in = SW'(sum);
    end
  end

  assign slot_sel = (op_e'(in_i.op) == OP_TICK) ? head_q : slot_in;

  // memories
  logic           busy_we, busy_wdata, busy_rd;
  logic [RW-1:0]  busy_waddr;
  logic           meta_we;
  logic [MTW-1:0] meta_wdata, meta_rd;
  logic           move_we;
  logic [AW-1:0]  move_waddr, move_raddr;
  logic [MVW-1:0] move_wdata, move_rd;

  dww_ram #(.DW(1), .DEPTH(REG_COUNT)) u_busy (
    .clk_i   (clk_i),
    .we_i    (busy_we),
    .waddr_i (busy_waddr),
    .wdata_i (busy_wdata),
    .raddr_i (dm_in),
    .rdata_o (busy_rd)
  );

  dww_ram #(.DW(MTW), .DEPTH(WHEEL_SLOTS)) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (slot_q),
    .wdata_i (meta_wdata),
    .raddr_i (slot_sel),
    .rdata_o (meta_rd)
  );

  dww_ram #(.DW(MVW), .DEPTH(MD)) u_move (
    .clk_i   (clk_i),
    .we_i    (move_we),
    .waddr_i (move_waddr),
    .wdata_i (move_wdata),
    .raddr_i (move_raddr),
    .rdata_o (move_rd)
  );

  logic [CW-1:0] m_cnt;
  logic          m_bv;
  logic [31:0]   m_t, m_h;
  logic          mv_rel;
  logic [RW-1:0] mv_dst;
  logic [63:0]   mv_val;

  assign m_cnt  = meta_rd[MTW-1 -: CW];
  assign m_bv   = meta_rd[64];
  assign m_t    = meta_rd[63:32];
  assign m_h    = meta_rd[31:0];
  assign mv_rel = move_rd[MVW-1];
  assign mv_dst = move_rd[MVW-2 -: RW];
  assign mv_val = move_rd[63:0];

  // slot state as seen in the execute cycle
  logic          e_vld, e_bv, rel, full;
  logic [CW-1:0] e_cnt, t_cnt;
  logic [CW+1:0] need, total;
  logic [AW-1:0] base;
  logic          out_free, walk_adv;

  assign e_vld = slot_vld_q[slot_q];
  assign e_cnt = e_vld ? m_cnt : '0;
  assign e_bv  = e_vld & m_bv;
  assign rel   = mark_q & ~busy_rd;
  assign need  = (wide_q ? (CW+2)'(2) : (CW+2)'(1)) + (CW+2)'(rel);
  assign total = {2'b00, e_cnt} + need;
  assign full  = total > (CW+2)'(MOVES_PER_SLOT);
  assign t_cnt = (e_cnt > CW'(MOVES_PER_SLOT)) ? CW'(MOVES_PER_SLOT) : e_cnt;
  assign base  = AW'(slot_q) * AW'(MOVES_PER_SLOT);

  assign out_free = ~out_valid_q | out_o.ready;
  assign walk_adv = mv_rel | ~pend_q | out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == RW'(REG_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (op_q)
          OP_WRITE: begin
            if (full) state_d = S_REPLY;
            else if (wide_q) state_d = S_PUSH_HI;
            else if (rel) state_d = S_PUSH_REL;
            else state_d = S_REPLY;
          end
          OP_TICK: begin
            state_d = (t_cnt == '0) ? S_FLUSH : S_WALK_RD;
          end
          default: state_d = S_REPLY;
        endcase
      end
      S_PUSH_HI:  state_d = rel_q ? S_PUSH_REL : S_REPLY;
      S_PUSH_REL: state_d = S_REPLY;
      S_REPLY: begin
        if (out_free) state_d = S_IDLE;
      end
      S_WALK_RD: state_d = S_WALK_EX;
      S_WALK_EX: begin
        if (walk_adv) state_d = (p_q + CW'(1) == cnt_q) ? S_FLUSH : S_WALK_RD;
      end
      S_FLUSH: begin
        if (pend_q) begin
          if (out_free) state_d = br_vld_q ? S_BRANCH : S_IDLE;
        end else if (br_vld_q) begin
          state_d = S_BRANCH;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_BRANCH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  logic          in_ready, emit, e_last, e_busy;
  kind_e         e_kind;
  status_e       e_status;
  logic [7:0]    e_reg;
  logic [63:0]   e_val;
  logic [31:0]   e_t, e_h;

  always_comb begin
    in_ready   = 1'b0;
    busy_we    = 1'b0;
    busy_waddr = dest_q;
    busy_wdata = 1'b0;
    meta_we    = 1'b0;
    meta_wdata = {e_cnt, e_bv, m_t, m_h};
    move_we    = 1'b0;
    move_waddr = base + AW'(idx_q);
    move_wdata = {1'b0, dest_q, value_q};
    move_raddr = base + AW'(p_q);
    emit       = 1'b0;
    e_kind     = KIND_STATUS;
    e_status   = STAT_OK;
    e_reg      = '0;
    e_val      = '0;
    e_busy     = 1'b0;
    e_t        = '0;
    e_h        = '0;
    e_last     = 1'b1;
    case (state_q)
      S_CLEAR: begin
        busy_we    = 1'b1;
        busy_waddr = clr_q;
      end
      S_IDLE: in_ready = 1'b1;
      S_EXEC: begin
        case (op_q)
          OP_WRITE: begin
            if (!full) begin
              move_we    = 1'b1;
              move_waddr = base + AW'(e_cnt);
              meta_we    = 1'b1;
              meta_wdata = {CW'(total), e_bv, m_t, m_h};
              busy_we    = rel;
              busy_wdata = 1'b1;
            end
          end
          OP_BRANCH: begin
            if (!e_bv) begin
              meta_we    = 1'b1;
              meta_wdata = {e_cnt, 1'b1, target_q, handler_q};
            end
          end
          default: ;
        endcase
      end
      S_PUSH_HI: begin
        move_we    = 1'b1;
        move_wdata = {1'b0, dp1_q, value_hi_q};
      end
      S_PUSH_REL: begin
        move_we    = 1'b1;
        move_wdata = {1'b1, dest_q, 64'd0};
      end
      S_REPLY: begin
        emit     = out_free;
        e_kind   = rkind_q;
        e_status = rstatus_q;
        e_busy   = rbusy_q;
      end
      S_WALK_EX: begin
        if (mv_rel) begin
          busy_we    = 1'b1;
          busy_waddr = mv_dst;
        end else if (pend_q) begin
          emit   = out_free;
          e_kind = KIND_WRITE;
          e_reg  = 8'(pend_reg_q);
          e_val  = pend_val_q;
          e_last = 1'b0;
        end
      end
      S_FLUSH: begin
        if (pend_q) begin
          emit   = out_free;
          e_kind = KIND_WRITE;
          e_reg  = 8'(pend_reg_q);
          e_val  = pend_val_q;
          e_last = ~br_vld_q;
        end else if (!br_vld_q) begin
          emit   = out_free;
          e_kind = KIND_EMPTY;
        end
      end
      S_BRANCH: begin
        emit   = out_free;
        e_kind = KIND_BRANCH;
        e_t    = br_t_q;
        e_h    = br_h_q;
      end
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      head_q      <= '0;
      slot_vld_q  <= '0;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + RW'(1);
      if (state_q == S_EXEC) begin
        case (op_q)
          OP_WRITE:  if (!full) slot_vld_q[slot_q] <= 1'b1;
          OP_BRANCH: if (!e_bv) slot_vld_q[slot_q] <= 1'b1;
          OP_TICK: begin
            slot_vld_q[slot_q] <= 1'b0;
            head_q  <= (head_q == SW'(WHEEL_SLOTS - 1)) ? '0 : head_q + SW'(1);
            pend_q  <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_q == S_WALK_EX && walk_adv && !mv_rel) pend_q <= 1'b1;
      if (state_q == S_FLUSH && pend_q && out_free) pend_q <= 1'b0;
      if (emit) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      op_q       <= op_e'(in_i.op);
      dest_q     <= dm_in;
      dp1_q      <= (dm_in == RW'(REG_COUNT - 1)) ? '0 : dm_in + RW'(1);
      value_q    <= in_i.value;
      value_hi_q <= in_i.value_hi;
      wide_q     <= in_i.wide;
      mark_q     <= in_i.mark_busy;
      slot_q     <= slot_sel;
      target_q   <= in_i.target;
      handler_q  <= in_i.handler;
    end
    if (state_q == S_EXEC) begin
      rel_q     <= rel;
      idx_q     <= e_cnt + CW'(1);
      rkind_q   <= KIND_STATUS;
      rstatus_q <= STAT_OK;
      rbusy_q   <= 1'b0;
      case (op_q)
        OP_WRITE:  if (full) rstatus_q <= STAT_FULL;
        OP_BRANCH: if (e_bv) rstatus_q <= STAT_CONFLICT;
        OP_QUERY: begin
          rkind_q <= KIND_BUSY;
          rbusy_q <= busy_rd;
        end
        default: begin
          cnt_q    <= t_cnt;
          p_q      <= '0;
          br_vld_q <= e_bv;
          br_t_q   <= m_t;
          br_h_q   <= m_h;
        end
      endcase
    end
    if (state_q == S_PUSH_HI) idx_q <= idx_q + CW'(1);
    if (state_q == S_WALK_EX && walk_adv) begin
      p_q <= p_q + CW'(1);
      if (!mv_rel) begin
        pend_reg_q <= mv_dst;
        pend_val_q <= mv_val;
      end
    end
    if (emit) begin
      o_kind_q   <= e_kind;
      o_status_q <= e_status;
      o_reg_q    <= e_reg;
      o_val_q    <= e_val;
      o_busy_q   <= e_busy;
      o_t_q      <= e_t;
      o_h_q      <= e_h;
      o_last_q   <= e_last;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = o_kind_q;
  assign out_o.status         = o_status_q;
  assign out_o.reg_index      = o_reg_q;
  assign out_o.write_value    = o_val_q;
  assign out_o.busy_res       = o_busy_q;
  assign out_o.branch_target  = o_t_q;
  assign out_o.branch_handler = o_h_q;
  assign out_o.last           = o_last_q;
endmodule
`default_nettype wire

// ----- sv/dww_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dww_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dww_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire
